@@ src/pst_pkg.sv @@
package pst_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 64;
   localparam int TIME_W  = 48;
   localparam int CAP_W   = 26;
   localparam int BURST_W = 16;
   localparam int RATE_W  = 20;
   localparam int PROD_W  = CAP_W + RATE_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] MILLI = CAP_W'(1000);

   localparam logic [CSR_IDX_W-1:0] CSR_BURST = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RATE  = CSR_IDX_W'(1);

   localparam logic [1:0] VERDICT_ALLOW = 2'd0;
   localparam logic [1:0] VERDICT_DENY  = 2'd1;
   localparam logic [1:0] VERDICT_FULL  = 2'd2;
   localparam logic [1:0] VERDICT_PRUNE = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  addr_hi;
      logic [KEY_W-1:0]  addr_lo;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [6:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [CAP_W-1:0]  token_level;
      logic [TIME_W-1:0] last_seen_ms;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic             set_valid;
      logic             clr_valid;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

endpackage

@@ src/pst_div.sv @@
module pst_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pst_pkg::CAP_W-1:0]       dividend,
   input  logic [pst_pkg::RATE_W-1:0]      divisor,
   output logic                            done,
   output logic [pst_pkg::CAP_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(pst_pkg::CAP_W);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [pst_pkg::CAP_W-1:0]     quo_ff, quo_in;
   logic [pst_pkg::RATE_W-1:0]    rem_ff, rem_in;
   logic [pst_pkg::RATE_W-1:0]    dvs_ff, dvs_in;
   logic [pst_pkg::RATE_W:0]      trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[pst_pkg::CAP_W-1]};
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(pst_pkg::CAP_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = pst_pkg::RATE_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[pst_pkg::CAP_W-2:0], 1'b1};
         end else begin
            rem_in = pst_pkg::RATE_W'(trial);
            quo_in = {quo_ff[pst_pkg::CAP_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/pst_table.sv @@
module pst_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pst_pkg::IDX_W-1:0]         rd_addr,
   output pst_pkg::entry_type                rd_data,
   input  pst_pkg::tbl_wr_type               wr,
   output logic [pst_pkg::ENTRIES-1:0]       valid
);

   pst_pkg::entry_type              mem [pst_pkg::ENTRIES];
   pst_pkg::entry_type              rd_ff;
   logic [pst_pkg::ENTRIES-1:0]     valid_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.set_valid) begin
         valid_ff[wr.addr] <= 1'b1;
      end else if (wr.clr_valid) begin
         valid_ff[wr.addr] <= 1'b0;
      end
   end

   assign rd_data = rd_ff;
   assign valid   = valid_ff;

endmodule

@@ src/per_source_token_bucket.sv @@
// Per-source token bucket policer over a table of ENTRIES buckets keyed by a
// 128-bit source address.
// Request channel: drive req_data and raise start; the transfer happens at the
// edge where start is high and busy is low. busy stays high until the result.
// Result channel: rsp_valid strobes for exactly one cycle with rsp_data; the
// receiver cannot stall, so take the result in that cycle.
// Config: csr_valid/csr_ready write channel (index 0 burst, 1 rate); write only
// while busy is low. csr_ready is always high.
// Operation: one item at a time. The table sits in one memory read one entry per
// cycle, so a request walks the table: a hit stops the walk and the entry goes
// through the elapsed, multiply and update steps; a miss walks all entries, then
// a new entry takes the same steps or the full verdict is given. A prune first
// runs the restoring divider for the idle limit, then walks all ENTRIES entries;
// with a zero rate it answers in the cycle after the transfer, without busy.
// Reset clears every valid bit at once and loads burst 10, rate 5; no
// clearing pass is needed.
module per_source_token_bucket (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pst_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output pst_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pst_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pst_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_SCAN = 6'b000100,
      S_ELAP = 6'b001000,
      S_MUL  = 6'b010000,
      S_UPD  = 6'b100000
   } state_type;

   localparam logic [pst_pkg::IDX_W-1:0] LAST_IDX = pst_pkg::IDX_W'(pst_pkg::ENTRIES - 1);

   state_type                        state_ff, state_in;
   pst_pkg::req_type                 req_ff, req_in;
   logic [pst_pkg::IDX_W-1:0]        iss_ff, iss_in;
   logic [pst_pkg::IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic                             chk_on_ff, chk_on_in;
   logic                             free_ok_ff, free_ok_in;
   logic [pst_pkg::IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [pst_pkg::IDX_W-1:0]        slot_ff, slot_in;
   logic [pst_pkg::CAP_W-1:0]        level_ff, level_in;
   logic [pst_pkg::TIME_W-1:0]       last_ff, last_in;
   logic [pst_pkg::CAP_W-1:0]        elap_ff, elap_in;
   logic [pst_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [pst_pkg::CAP_W-1:0]        limit_ff, limit_in;
   logic [pst_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pst_pkg::rsp_type                 rsp_ff, rsp_in;
   logic [pst_pkg::BURST_W-1:0]      burst_ff, burst_in;
   logic [pst_pkg::RATE_W-1:0]       rate_ff, rate_in;

   logic                             accept;
   logic [pst_pkg::CAP_W-1:0]        cap;
   logic [pst_pkg::TIME_W-1:0]       diff;
   logic [pst_pkg::PROD_W:0]         sum;
   logic [pst_pkg::CAP_W-1:0]        lvl;
   logic                             cur_valid;
   logic                             key_hit;
   logic                             div_start;
   logic                             div_done;
   logic [pst_pkg::CAP_W-1:0]        div_quo;
   pst_pkg::entry_type               rd_data;
   pst_pkg::tbl_wr_type              wr;
   logic [pst_pkg::ENTRIES-1:0]      valid;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign cap       = pst_pkg::CAP_W'(burst_ff) * pst_pkg::MILLI;
   assign div_start = accept && req_data.kind && (rate_ff != '0);

   assign cur_valid = valid[chk_idx_ff];
   assign key_hit   = cur_valid && (rd_data.key_high == req_ff.addr_hi)
                      && (rd_data.key_low == req_ff.addr_lo);
   assign diff      = (req_ff.now_ms > last_ff) ? (req_ff.now_ms - last_ff) : '0;
   assign sum       = (pst_pkg::PROD_W + 1)'(level_ff) + {1'b0, prod_ff};
   assign lvl       = (sum > (pst_pkg::PROD_W + 1)'(cap)) ? cap : pst_pkg::CAP_W'(sum);

   pst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cap),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   pst_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (iss_ff),
      .rd_data (rd_data),
      .wr      (wr),
      .valid   (valid)
   );

   // config writes: keep only the register's own width
   always_comb begin
      burst_in = burst_ff;
      rate_in  = rate_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pst_pkg::CSR_BURST: burst_in = pst_pkg::BURST_W'(csr_wdata);
            pst_pkg::CSR_RATE:  rate_in  = pst_pkg::RATE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      iss_in       = iss_ff;
      chk_idx_in   = chk_idx_ff;
      chk_on_in    = chk_on_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      slot_in      = slot_ff;
      level_in     = level_ff;
      last_in      = last_ff;
      elap_in      = elap_ff;
      prod_in      = prod_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr           = '0;
      wr.addr      = chk_idx_ff;
      wr.data      = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               iss_in     = '0;
               chk_on_in  = 1'b0;
               free_ok_in = 1'b0;
               cnt_in     = '0;
               if (!req_data.kind) begin
                  state_in = S_SCAN;
               end else if (rate_ff != '0) begin
                  state_in = S_DIV;
               end else begin
                  // zero rate: idle limit is infinite, remove nothing
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{verdict: pst_pkg::VERDICT_PRUNE, removed_count: 7'd0};
               end
            end
         end

         S_DIV: begin
            if (div_done) begin
               limit_in = div_quo;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // issue the next read while checking the entry read last cycle
            chk_idx_in = iss_ff;
            chk_on_in  = 1'b1;
            if (iss_ff != LAST_IDX) begin
               iss_in = iss_ff + 1'b1;
            end
            if (chk_on_ff) begin
               if (req_ff.kind) begin
                  if (cur_valid && (req_ff.now_ms > rd_data.last_seen_ms)
                      && ((req_ff.now_ms - rd_data.last_seen_ms)
                          > pst_pkg::TIME_W'(limit_ff))) begin
                     wr.clr_valid = 1'b1;
                     cnt_in       = cnt_ff + 1'b1;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.verdict       = pst_pkg::VERDICT_PRUNE;
                     rsp_in.removed_count = 7'(cnt_in);
                     state_in = S_IDLE;
                  end
               end else if (key_hit) begin
                  slot_in  = chk_idx_ff;
                  level_in = rd_data.token_level;
                  last_in  = rd_data.last_seen_ms;
                  state_in = S_ELAP;
               end else begin
                  if (!cur_valid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     if (free_ok_in) begin
                        // new entry starts full with nothing elapsed
                        slot_in  = free_idx_in;
                        level_in = cap;
                        last_in  = req_ff.now_ms;
                        state_in = S_ELAP;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{verdict: pst_pkg::VERDICT_FULL, removed_count: 7'd0};
                        state_in = S_IDLE;
                     end
                  end
               end
            end
         end

         S_ELAP: begin
            // clamp elapsed time to the capacity to keep the product narrow
            elap_in  = (diff > pst_pkg::TIME_W'(cap)) ? cap : pst_pkg::CAP_W'(diff);
            state_in = S_MUL;
         end

         S_MUL: begin
            prod_in  = pst_pkg::PROD_W'(elap_ff) * pst_pkg::PROD_W'(rate_ff);
            state_in = S_UPD;
         end

         S_UPD: begin
            wr.we                = 1'b1;
            wr.set_valid         = 1'b1;
            wr.addr              = slot_ff;
            wr.data.key_high     = req_ff.addr_hi;
            wr.data.key_low      = req_ff.addr_lo;
            wr.data.last_seen_ms = req_ff.now_ms;
            rsp_valid_in         = 1'b1;
            rsp_in.removed_count = 7'd0;
            if (lvl < pst_pkg::MILLI) begin
               wr.data.token_level = lvl;
               rsp_in.verdict      = pst_pkg::VERDICT_DENY;
            end else begin
               wr.data.token_level = lvl - pst_pkg::MILLI;
               rsp_in.verdict      = pst_pkg::VERDICT_ALLOW;
            end
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         burst_ff     <= pst_pkg::BURST_W'(10);
         rate_ff      <= pst_pkg::RATE_W'(5);
         chk_on_ff    <= 1'b0;
         free_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         burst_ff     <= burst_in;
         rate_ff      <= rate_in;
         chk_on_ff    <= chk_on_in;
         free_ok_ff   <= free_ok_in;
      end
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
      level_ff    <= level_in;
      last_ff     <= last_in;
      elap_ff     <= elap_in;
      prod_ff     <= prod_in;
      limit_ff    <= limit_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while an item is still in progress");

   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(accept))
      else $error("block went busy without a transfer");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && !(req_data.kind && rate_ff == '0)) |=> busy)
      else $error("transfer accepted but block not busy");

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.verdict != pst_pkg::VERDICT_PRUNE)
      |-> (rsp_data.removed_count == 7'd0))
      else $error("request result carries a removed count");
`endif

endmodule

@@ verif/per_source_token_bucket_test.sv @@
`timescale 1ns / 1ps

module per_source_token_bucket_test;

   // Shadow copy of the bucket table and registers, kept at the block's widths.
   class bucket_scoreboard;
      logic [pst_pkg::BURST_W-1:0] burst;
      logic [pst_pkg::RATE_W-1:0]  rate;
      bit                          live [pst_pkg::ENTRIES];
      logic [pst_pkg::KEY_W-1:0]   khi [pst_pkg::ENTRIES];
      logic [pst_pkg::KEY_W-1:0]   klo [pst_pkg::ENTRIES];
      logic [63:0]                 level [pst_pkg::ENTRIES];
      logic [pst_pkg::TIME_W-1:0]  seen [pst_pkg::ENTRIES];
      pst_pkg::rsp_type            pending [$];
      int                          errors;

      function void clear();
         burst = pst_pkg::BURST_W'(10);
         rate = pst_pkg::RATE_W'(5);
         foreach (live[i]) live[i] = 1'b0;
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [pst_pkg::CSR_IDX_W-1:0] idx,
                              logic [pst_pkg::CSR_DATA_W-1:0] d);
         if (idx == pst_pkg::CSR_BURST) burst = d[pst_pkg::BURST_W-1:0];
         else if (idx == pst_pkg::CSR_RATE) rate = d[pst_pkg::RATE_W-1:0];
      endfunction

      function logic [1:0] admit(pst_pkg::req_type r);
         logic [63:0] cap, gap, lvl;
         int slot;
         cap = 64'(burst) * 64'd1000;
         slot = -1;
         for (int i = 0; i < pst_pkg::ENTRIES; i++)
            if (slot < 0 && live[i] && khi[i] == r.addr_hi && klo[i] == r.addr_lo) slot = i;
         if (slot < 0) begin
            for (int i = 0; i < pst_pkg::ENTRIES; i++)
               if (slot < 0 && !live[i]) slot = i;
            if (slot < 0) return pst_pkg::VERDICT_FULL;
            live[slot] = 1'b1;
            khi[slot] = r.addr_hi;
            klo[slot] = r.addr_lo;
            level[slot] = cap & 64'h3FFFFFF;
            seen[slot] = r.now_ms;
         end
         gap = (r.now_ms > seen[slot]) ? 64'(r.now_ms - seen[slot]) : 64'd0;
         if (gap > cap) gap = cap;
         lvl = level[slot] + gap * 64'(rate);
         if (lvl > cap) lvl = cap;
         seen[slot] = r.now_ms;
         if (lvl < 64'd1000) begin
            level[slot] = lvl & 64'h3FFFFFF;
            return pst_pkg::VERDICT_DENY;
         end
         level[slot] = (lvl - 64'd1000) & 64'h3FFFFFF;
         return pst_pkg::VERDICT_ALLOW;
      endfunction

      function logic [6:0] prune(logic [pst_pkg::TIME_W-1:0] now);
         logic [63:0] idle_max;
         int n;
         n = 0;
         if (rate == '0) return 7'd0;
         idle_max = (64'(burst) * 64'd1000) / 64'(rate);
         for (int i = 0; i < pst_pkg::ENTRIES; i++)
            if (live[i] && now > seen[i] && 64'(now - seen[i]) > idle_max) begin
               live[i] = 1'b0;
               n++;
            end
         return 7'(n);
      endfunction

      // Note an accepted request transfer and queue what it must produce.
      function void note_request(pst_pkg::req_type r);
         pst_pkg::rsp_type e;
         e.verdict = r.kind ? pst_pkg::VERDICT_PRUNE : admit(r);
         e.removed_count = r.kind ? prune(r.now_ms) : 7'd0;
         pending = {pending, e};
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(pst_pkg::rsp_type got);
         pst_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         e = pending.pop_front();
         if (got.verdict !== e.verdict)
            report($sformatf("verdict %0d, wanted %0d", got.verdict, e.verdict));
         if (got.removed_count !== e.removed_count)
            report($sformatf("removed %0d, wanted %0d", got.removed_count, e.removed_count));
      endtask
   endclass

   logic clock = 0, reset = 1, start = 0, busy, rsp_valid, csr_valid = 0, csr_ready;
   pst_pkg::req_type req_data = '0;
   pst_pkg::rsp_type rsp_data;
   logic [pst_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pst_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bucket_scoreboard sb = new();
   logic [pst_pkg::TIME_W-1:0] clock_ms;
   logic [pst_pkg::KEY_W-1:0]  pool_hi [8];
   logic [pst_pkg::KEY_W-1:0]  pool_lo [8];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   per_source_token_bucket DUT (.*);

   // Results cannot be held off: take every strobe as it comes.
   always @(posedge clock)
      if (!reset && rsp_valid) sb.check_result(rsp_data);

   // start is left high after a transfer; the next call or an idle spell drops it.
   task automatic send(logic k, logic [pst_pkg::KEY_W-1:0] hi, logic [pst_pkg::KEY_W-1:0] lo,
                       logic [pst_pkg::TIME_W-1:0] now);
      int gap;
      pst_pkg::req_type r;
      gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 18));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.kind = k; r.addr_hi = hi; r.addr_lo = lo; r.now_ms = now;
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Transfer taken at this edge.
      sb.note_request(r);
   endtask

   // Drain every result, wait out any tail, then write one register.
   task automatic write_csr(logic [pst_pkg::CSR_IDX_W-1:0] idx,
                            logic [pst_pkg::CSR_DATA_W-1:0] d);
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (pst_pkg::ENTRIES + 40) @(posedge clock);
      csr_index <= idx;
      csr_wdata <= d;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, d);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(logic [15:0] b, logic [19:0] r);
      write_csr(pst_pkg::CSR_BURST, 32'(b));
      write_csr(pst_pkg::CSR_RATE, 32'(r));
   endtask

   // Mostly revisit a few hot addresses with time creeping forward.
   task automatic random_phase(int n);
      int p;
      for (int i = 0; i < n; i++) begin
         p = int'($urandom_range(0, 99));
         if ($urandom_range(0, 9) == 0)
            clock_ms = clock_ms - pst_pkg::TIME_W'($urandom_range(0, 500));
         else
            clock_ms = clock_ms + pst_pkg::TIME_W'($urandom_range(0, 3000));
         if (p < 8)
            send(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, clock_ms);
         else if (p < 75)
            send(1'b0, pool_hi[p % 8], pool_lo[p % 8], clock_ms);
         else
            send(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, clock_ms);
      end
   endtask

   initial begin
      #200000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      sb.clear();
      for (int i = 0; i < 8; i++) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
      end
      pool_hi[0] = '0; pool_lo[0] = '0;
      pool_hi[1] = '1; pool_lo[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, draining a bucket, time backwards, prune.
      send(1'b0, '0, '0, '0);
      send(1'b0, '1, '1, '1);
      send(1'b0, '1, '1, '0);
      for (int i = 0; i < 12; i++) send(1'b0, 64'h5, 64'h6, 48'd100);
      send(1'b0, 64'h5, 64'h6, 48'd50);
      send(1'b1, '0, '0, 48'd100);
      send(1'b1, '1, '1, 48'd5000);
      send(1'b1, '0, '0, '1);
      // Fill the table, then meet it full.
      for (int i = 0; i < pst_pkg::ENTRIES + 2; i++) send(1'b0, 64'(i), 64'hA5, 48'd10);
      send(1'b1, '0, '0, 48'd10000);

      // Zero burst, zero rate, lowered burst, and the maxima.
      set_regs(16'd0, 20'd5);
      send(1'b0, 64'h5, 64'h6, 48'd20000);
      set_regs(16'd3, 20'd0);
      send(1'b0, 64'h7, 64'h7, 48'd1);
      send(1'b1, '0, '0, '1);
      set_regs(16'hFFFF, 20'hFFFFF);
      send(1'b0, 64'h7, 64'h7, 48'd90000);
      set_regs(16'd2, 20'd1);
      send(1'b0, 64'h7, 64'h7, 48'd90001);

      clock_ms = 48'd1000;
      set_regs(16'd10, 20'd5);
      random_phase(150);
      set_regs(16'd1, 20'd1000);
      random_phase(150);
      set_regs(16'hFFFF, 20'hFFFFF);
      random_phase(100);
      set_regs(16'd4, 20'd2);
      random_phase(100);
      set_regs(16'd0, 20'd0);
      random_phase(50);
      set_regs(16'($urandom), 20'($urandom));
      random_phase(50);

      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (pst_pkg::ENTRIES + 40) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
